>>> src/premultiplied_coverage_blend_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef PREMULTIPLIED_COVERAGE_BLEND_UNIT_DEFINES_SVH
`define PREMULTIPLIED_COVERAGE_BLEND_UNIT_DEFINES_SVH

// General property, sampled on clk_i and switched off while in reset
`define PCB_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pcb assertion failed");

// Condition that must never be seen outside reset
`define PCB_ASSERT_NEVER(label, cond) \
  `PCB_ASSERT(label, !(cond))

`endif

>>> src/pcb_pkg.sv
package pcb_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ProdW    = 2 * ByteW;
  localparam logic [ByteW-1:0] ByteMax = 8'hFF;
  // depth of the valid shift register that carries each accepted item to its done strobe
  localparam int unsigned Latency  = 4;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [ProdW-1:0] prod_t;

  // divide by 255 with the truncating shift form; exact for v <= 255*255
  function automatic byte_t scale_down(prod_t v);
    logic [ProdW:0] s;
    s = {1'b0, v} + (ProdW+1)'(1) + (ProdW+1)'(v[ProdW-1:ByteW]);
    return s[ProdW-1:ByteW];
  endfunction

endpackage

>>> src/pcb_lane.sv
module pcb_lane
  import pcb_pkg::*;
(
  input  logic  clk_i,
  input  byte_t src_i,
  input  byte_t dst_i,
  input  byte_t alpha_i,
  input  byte_t keep_i,
  output byte_t res_o
);

  prod_t prod_src_q, prod_src_d;
  prod_t prod_dst_q, prod_dst_d;
  byte_t res_q, res_d;
  logic [ByteW:0] sum;

  // first stage: the two 8x8 products
  assign prod_src_d = prod_t'(src_i) * prod_t'(alpha_i);
  assign prod_dst_d = prod_t'(dst_i) * prod_t'(keep_i);

  always_ff @(posedge clk_i) begin
    prod_src_q <= prod_src_d;
    prod_dst_q <= prod_dst_d;
  end

  // second stage: scale, add and saturate
  assign sum   = {1'b0, scale_down(prod_src_q)} + {1'b0, scale_down(prod_dst_q)};
  assign res_d = sum[ByteW] ? ByteMax : sum[ByteW-1:0];

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> src/premultiplied_coverage_blend_unit.sv
// Source-over blend of a coverage-masked solid colour onto one premultiplied
// BGRA pixel.
// Input channel: drive the pixel fields and pulse start_i; an item is taken
// at every rising edge where start_i is high and busy_o is low. busy_o stays
// low, so a new pixel may be offered on every clock.
// Result channel: out_*_o carry the blended pixel for exactly one cycle,
// marked by done_o.
// Each pixel passes the four-stage pipeline (coverage product, alpha
// scaling, channel products, sum and clamp) from the accepting edge to
// done_o. Throughput: one pixel per clock.
// Reset (rst_ni low, asynchronous) clears the stage valid bits, dropping any
// pixels in flight; the datapath registers are not reset.
// The receiver cannot stall: results leave on a fixed schedule, and the
// pipeline never holds.
// Zero coverage or full transparency gives alpha zero, which returns the
// destination pixel unchanged.
module premultiplied_coverage_blend_unit
  import pcb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  input  byte_t coverage_i,
  input  byte_t src_red_i,
  input  byte_t src_green_i,
  input  byte_t src_blue_i,
  input  byte_t transparency_i,
  input  byte_t dst_blue_i,
  input  byte_t dst_green_i,
  input  byte_t dst_red_i,
  input  byte_t dst_alpha_i,
  output logic  done_o,
  output byte_t out_blue_o,
  output byte_t out_green_o,
  output byte_t out_red_o,
  output byte_t out_alpha_o
);

  logic               accept;
  logic [Latency-1:0] vld_q, vld_d;

  // stage 1: coverage times opacity, pixel captured
  prod_t cov_prod_q, cov_prod_d;
  byte_t s1_sr_q, s1_sg_q, s1_sb_q;
  byte_t s1_db_q, s1_dg_q, s1_dr_q, s1_da_q;

  // stage 2: alpha and its complement
  byte_t alpha_q, alpha_d;
  byte_t keep_q, keep_d;
  byte_t s2_sr_q, s2_sg_q, s2_sb_q;
  byte_t s2_db_q, s2_dg_q, s2_dr_q, s2_da_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // valid bits run alongside the data
  assign vld_d = {vld_q[Latency-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign cov_prod_d = prod_t'(coverage_i) * prod_t'(ByteMax - transparency_i);

  always_ff @(posedge clk_i) begin
    cov_prod_q <= cov_prod_d;
    s1_sr_q    <= src_red_i;
    s1_sg_q    <= src_green_i;
    s1_sb_q    <= src_blue_i;
    s1_db_q    <= dst_blue_i;
    s1_dg_q    <= dst_green_i;
    s1_dr_q    <= dst_red_i;
    s1_da_q    <= dst_alpha_i;
  end

  // zero coverage yields zero alpha here, so no separate bypass is needed
  assign alpha_d = scale_down(cov_prod_q);
  assign keep_d  = ByteMax - alpha_d;

  always_ff @(posedge clk_i) begin
    alpha_q <= alpha_d;
    keep_q  <= keep_d;
    s2_sr_q <= s1_sr_q;
    s2_sg_q <= s1_sg_q;
    s2_sb_q <= s1_sb_q;
    s2_db_q <= s1_db_q;
    s2_dg_q <= s1_dg_q;
    s2_dr_q <= s1_dr_q;
    s2_da_q <= s1_da_q;
  end

  // stages 3 and 4: one lane per channel
  pcb_lane u_lane_blue (
    .clk_i   (clk_i),
    .src_i   (s2_sb_q),
    .dst_i   (s2_db_q),
    .alpha_i (alpha_q),
    .keep_i  (keep_q),
    .res_o   (out_blue_o)
  );

  pcb_lane u_lane_green (
    .clk_i   (clk_i),
    .src_i   (s2_sg_q),
    .dst_i   (s2_dg_q),
    .alpha_i (alpha_q),
    .keep_i  (keep_q),
    .res_o   (out_green_o)
  );

  pcb_lane u_lane_red (
    .clk_i   (clk_i),
    .src_i   (s2_sr_q),
    .dst_i   (s2_dr_q),
    .alpha_i (alpha_q),
    .keep_i  (keep_q),
    .res_o   (out_red_o)
  );

  // alpha lane: full source scales back to alpha itself
  pcb_lane u_lane_alpha (
    .clk_i   (clk_i),
    .src_i   (ByteMax),
    .dst_i   (s2_da_q),
    .alpha_i (alpha_q),
    .keep_i  (keep_q),
    .res_o   (out_alpha_o)
  );

  assign done_o = vld_q[Latency-1];

endmodule

>>> src/pcb_checker.sv
`include "premultiplied_coverage_blend_unit_defines.svh"

module pcb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [7:0] coverage_i,
  input logic [7:0] transparency_i,
  input logic [7:0] dst_blue_i,
  input logic [7:0] dst_green_i,
  input logic [7:0] dst_red_i,
  input logic [7:0] dst_alpha_i,
  input logic       done_o,
  input logic [7:0] out_blue_o,
  input logic [7:0] out_green_o,
  input logic [7:0] out_red_o,
  input logic [7:0] out_alpha_o
);

  logic        item_taken;
  logic        clear_px;
  logic [31:0] dst_px;
  logic [31:0] out_px;

  assign item_taken = start_i && !busy_o;
  assign clear_px   = (coverage_i == 8'h00) || (transparency_i == 8'hFF);
  assign dst_px     = {dst_blue_i, dst_green_i, dst_red_i, dst_alpha_i};
  assign out_px     = {out_blue_o, out_green_o, out_red_o, out_alpha_o};

  // the pipeline never holds off the sender
  `PCB_ASSERT_NEVER(busy_never_a, busy_o)

  // every accepted item comes out with a done strobe
  `PCB_ASSERT(accept_done_a, item_taken |-> ##4 done_o)

  // no strobe without an earlier accepted item
  `PCB_ASSERT(done_origin_a, done_o |-> $past(item_taken, 4))

  // zero alpha passes the destination pixel through
  `PCB_ASSERT(pass_through_a, (item_taken && clear_px) |-> ##4 (out_px == $past(dst_px, 4)))

endmodule

bind premultiplied_coverage_blend_unit pcb_checker u_pcb_checker (.*);

>>> test/premultiplied_coverage_blend_unit_tb.sv
`timescale 1ns / 100ps

module premultiplied_coverage_blend_unit_tb;
  import pcb_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomPerPhase = 510;

  // one source pixel plus its destination pixel
  typedef struct packed {
    byte_t coverage;
    byte_t src_red;
    byte_t src_green;
    byte_t src_blue;
    byte_t transparency;
    byte_t dst_blue;
    byte_t dst_green;
    byte_t dst_red;
    byte_t dst_alpha;
  } pixel_in_t;

  typedef struct packed {
    byte_t blue;
    byte_t green;
    byte_t red;
    byte_t alpha;
  } pixel_out_t;

  logic  clk_i          = 1'b0;
  logic  rst_ni         = 1'b0;
  logic  start_i        = 1'b0;
  byte_t coverage_i     = '0;
  byte_t src_red_i      = '0;
  byte_t src_green_i    = '0;
  byte_t src_blue_i     = '0;
  byte_t transparency_i = '0;
  byte_t dst_blue_i     = '0;
  byte_t dst_green_i    = '0;
  byte_t dst_red_i      = '0;
  byte_t dst_alpha_i    = '0;
  logic  busy_o;
  logic  done_o;
  byte_t out_blue_o;
  byte_t out_green_o;
  byte_t out_red_o;
  byte_t out_alpha_o;

  pixel_out_t  blended_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;

  premultiplied_coverage_blend_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .coverage_i    (coverage_i),
    .src_red_i     (src_red_i),
    .src_green_i   (src_green_i),
    .src_blue_i    (src_blue_i),
    .transparency_i(transparency_i),
    .dst_blue_i    (dst_blue_i),
    .dst_green_i   (dst_green_i),
    .dst_red_i     (dst_red_i),
    .dst_alpha_i   (dst_alpha_i),
    .done_o        (done_o),
    .out_blue_o    (out_blue_o),
    .out_green_o   (out_green_o),
    .out_red_o     (out_red_o),
    .out_alpha_o   (out_alpha_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // divide by 255, truncating, via the add-and-shift form
  function automatic int unsigned div255(int unsigned v);
    return (v + 1 + (v >> 8)) >> 8;
  endfunction

  function automatic byte_t saturate_byte(int unsigned v);
    return (v > 255) ? 8'hFF : byte_t'(v);
  endfunction

  // source-over of the coverage-masked colour onto the destination
  function automatic pixel_out_t blend_over(pixel_in_t px);
    int unsigned alpha;
    int unsigned keep;
    pixel_out_t res;
    alpha = 0;
    if (px.coverage != 0)
      alpha = div255(int'(px.coverage) * (255 - int'(px.transparency)));
    if (alpha == 0) begin
      // nothing drawn: destination passes through
      res.blue  = px.dst_blue;
      res.green = px.dst_green;
      res.red   = px.dst_red;
      res.alpha = px.dst_alpha;
    end else begin
      keep = 255 - alpha;
      res.blue  = saturate_byte(div255(px.src_blue * alpha) + div255(px.dst_blue * keep));
      res.green = saturate_byte(div255(px.src_green * alpha) + div255(px.dst_green * keep));
      res.red   = saturate_byte(div255(px.src_red * alpha) + div255(px.dst_red * keep));
      res.alpha = saturate_byte(alpha + div255(px.dst_alpha * keep));
    end
    return res;
  endfunction

  function automatic pixel_in_t make_pixel(byte_t cov, byte_t sr, byte_t sg, byte_t sb,
                                           byte_t tr, byte_t db, byte_t dg, byte_t dr,
                                           byte_t da);
    return '{cov, sr, sg, sb, tr, db, dg, dr, da};
  endfunction

  // uniform pixels half the time, else weighted to pass-through, opaque or near-zero-product corners
  function automatic pixel_in_t random_pixel();
    pixel_in_t px;
    px = pixel_in_t'({$urandom, $urandom, $urandom});
    case ($urandom_range(9))
      0: px.coverage = 8'h00;
      1: px.coverage = 8'hFF;
      2: px.transparency = 8'hFF;
      3: px.transparency = 8'h00;
      4: begin
        // tiny product, which always rounds the alpha down to zero
        px.coverage     = byte_t'($urandom_range(1, 4));
        px.transparency = byte_t'($urandom_range(250, 255));
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic check_field(string name, byte_t want, byte_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // offer one item, with random idle cycles ahead of it; returns after acceptance
  task automatic send_pixel(pixel_in_t px);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    coverage_i     <= px.coverage;
    src_red_i      <= px.src_red;
    src_green_i    <= px.src_green;
    src_blue_i     <= px.src_blue;
    transparency_i <= px.transparency;
    dst_blue_i     <= px.dst_blue;
    dst_green_i    <= px.dst_green;
    dst_red_i      <= px.dst_red;
    dst_alpha_i    <= px.dst_alpha;
    start_i        <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned count, int unsigned idle_pct);
    sender_idle_pct = idle_pct;
    repeat (count) send_pixel(random_pixel());
  endtask

  // corners, pass-through cases and bit patterns
  task automatic test_edge_cases();
    sender_idle_pct = 0;
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'hAA, 8'h55));
    send_pixel(make_pixel(8'hC8, 8'h12, 8'h34, 8'h56, 8'hFF, 8'h9A, 8'hBC, 8'hDE, 8'hF0));
    send_pixel(make_pixel(8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'h10, 8'h20, 8'h30, 8'h40));
    send_pixel(make_pixel(8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h10, 8'h20, 8'h30, 8'h40));
    send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // near saturation: alpha of about a quarter over a full destination
    send_pixel(make_pixel(8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
    send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
    send_pixel(make_pixel(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80));
    send_pixel(make_pixel(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F));
    send_pixel(make_pixel(8'h02, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01, 8'hFE));
    send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00));
  endtask

  task automatic test_back_to_back();
    run_random(RandomPerPhase, 0);
  endtask

  task automatic test_sparse_sender();
    run_random(RandomPerPhase, 76);
  endtask

  task automatic test_mixed_gaps();
    run_random(RandomPerPhase, 36);
  endtask

  // results are checked before new items are logged, so a stray strobe cannot
  // match an item taken at the same edge
  always @(posedge clk_i) begin : track_pixels
    pixel_out_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (blended_q.size() == 0) begin
          $error("result with no item outstanding");
          mismatch_count++;
        end else begin
          want = blended_q.pop_front();
          check_field("out_blue", want.blue, out_blue_o);
          check_field("out_green", want.green, out_green_o);
          check_field("out_red", want.red, out_red_o);
          check_field("out_alpha", want.alpha, out_alpha_o);
        end
      end
      if (start_i && !busy_o)
        blended_q.push_back(blend_over(make_pixel(coverage_i, src_red_i, src_green_i,
                                                  src_blue_i, transparency_i, dst_blue_i,
                                                  dst_green_i, dst_red_i, dst_alpha_i)));
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_cases();
    test_back_to_back();
    test_sparse_sender();
    test_mixed_gaps();
    start_i <= 1'b0;

    // drain, then allow a few more cycles for stray strobes
    while (blended_q.size() != 0) @(posedge clk_i);
    repeat (2 * Latency + 4) @(posedge clk_i);

    if (mismatch_count == 0 && blended_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
